### hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is held
`define ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is held
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// next-cycle implication, also checked through reset
`define ASSERT_NEXT_RAW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/dlm_pkg.sv
`default_nettype none
package dlm_pkg;

    localparam int MAX_INPUTS  = 64;
    localparam int MAX_NEURONS = 64;
    localparam int ROW_LEN     = MAX_INPUTS + 1;
    localparam int W_DEPTH     = ROW_LEN * MAX_NEURONS;
    localparam int W_AW        = $clog2(W_DEPTH);
    localparam int V_AW        = $clog2(MAX_INPUTS);
    localparam int CNT_W       = 7;
    localparam int ROW_W       = 6;
    localparam int VAL_W       = 16;
    localparam int SUM_W       = 40;
    localparam int PROD_W      = 2 * VAL_W;
    localparam int OQ_DEPTH    = 4;
    localparam int OQ_AW       = $clog2(OQ_DEPTH);
    localparam int OQ_CW       = $clog2(OQ_DEPTH + 1);
    localparam int CQ_DEPTH    = 2;
    localparam int CQ_AW       = $clog2(CQ_DEPTH);
    localparam int CQ_CW       = $clog2(CQ_DEPTH + 1);

    localparam logic signed [VAL_W-1:0] BIAS_SCALE = 16'sd4096;

    localparam logic ACT_WEIGHT = 1'b0;
    localparam logic ACT_DATA   = 1'b1;

    localparam logic REG_INPUT_COUNT  = 1'b0;
    localparam logic REG_NEURON_COUNT = 1'b1;

    typedef struct packed {
        logic                    action;
        logic [ROW_W-1:0]        neuron_row;
        logic [CNT_W-1:0]        weight_column;
        logic signed [VAL_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic [ROW_W-1:0]        neuron_index;
        logic signed [SUM_W-1:0] sum_out;
        logic                    last_of_vector;
    } t_out_word;

    typedef struct packed {
        logic [CNT_W-1:0] n_in;
        logic [CNT_W-1:0] n_out;
    } t_cfg;

    typedef struct packed {
        logic                    is_elem;
        logic                    run;
        logic [W_AW-1:0]         addr;
        logic signed [VAL_W-1:0] value;
    } t_cmd;

    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] v,
                                                   input logic [CNT_W-1:0] max_v);
        logic [CNT_W-1:0] r;
        if (v == '0) begin
            r = CNT_W'(1);
        end else if (v > max_v) begin
            r = max_v;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### hdl/dlm_ram.sv
`default_nettype none
module dlm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### hdl/dlm_front.sv
`default_nettype none
module dlm_front import dlm_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cfg     i_cfg,
    input  wire logic     i_push,
    input  wire t_in_word i_word,
    output logic          o_full,
    input  wire logic     i_q_full,
    output logic          o_q_push,
    output t_cmd          o_q_cmd
);

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic [CNT_W-1:0] idx;
    logic             accept;
    logic             complete;
    logic             w_ok;

    always_comb begin
        accept   = i_push && !i_q_full;
        idx      = (r_cnt >= i_cfg.n_in) ? (i_cfg.n_in - CNT_W'(1)) : r_cnt;
        complete = (idx == (i_cfg.n_in - CNT_W'(1)));
        w_ok     = ({1'b0, i_word.neuron_row} < CNT_W'(MAX_NEURONS))
                   && (i_word.weight_column <= CNT_W'(MAX_INPUTS));

        n_cnt = r_cnt;
        if (accept && i_word.action == ACT_DATA) begin
            n_cnt = complete ? '0 : (idx + CNT_W'(1));
        end

        o_q_cmd.value = i_word.value;
        if (i_word.action == ACT_DATA) begin
            o_q_cmd.is_elem = 1'b1;
            o_q_cmd.run     = complete;
            o_q_cmd.addr    = W_AW'(idx);
            o_q_push        = accept;
        end else begin
            o_q_cmd.is_elem = 1'b0;
            o_q_cmd.run     = 1'b0;
            o_q_cmd.addr    = W_AW'(i_word.neuron_row) * W_AW'(ROW_LEN)
                              + W_AW'(i_word.weight_column);
            o_q_push        = accept && w_ok;
        end
        o_full = i_q_full;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule
`default_nettype wire

### hdl/dlm_cmdq.sv
`default_nettype none
module dlm_cmdq import dlm_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_cmd      o_cmd
);

    t_cmd             r_q [CQ_DEPTH];
    logic [CQ_AW-1:0] r_wp;
    logic [CQ_AW-1:0] r_rp;
    logic [CQ_CW-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    always_comb begin
        o_full  = (r_cnt == CQ_CW'(CQ_DEPTH));
        o_valid = (r_cnt != '0);
        o_cmd   = r_q[r_rp];
        do_push = i_push && !o_full;
        do_pop  = i_pop && o_valid;
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + CQ_AW'(1);
            end
            if (do_pop) begin
                r_rp <= r_rp + CQ_AW'(1);
            end
            r_cnt <= r_cnt + CQ_CW'(do_push) - CQ_CW'(do_pop);
        end
    end

endmodule
`default_nettype wire

### hdl/dlm_back.sv
`default_nettype none
module dlm_back import dlm_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire logic i_cmd_valid,
    input  wire t_cmd i_cmd,
    output logic      o_cmd_pop,
    output logic      o_empty,
    input  wire logic i_pop,
    output t_out_word o_word
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    typedef struct packed {
        logic             valid;
        logic             first;
        logic             bias;
        logic             lastn;
        logic [ROW_W-1:0] n;
    } t_tag;

    logic             r_state;
    logic             n_state;
    logic [CNT_W-1:0] r_i;
    logic [CNT_W-1:0] n_i;
    logic [ROW_W-1:0] r_n;
    logic [ROW_W-1:0] n_n;
    logic [W_AW-1:0]  r_base;
    logic [W_AW-1:0]  n_base;
    logic [OQ_CW-1:0] r_pend;

    t_tag             s0;
    t_tag             r_s1;
    t_tag             r_s2;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [SUM_W-1:0]  r_acc;
    logic signed [SUM_W-1:0]  acc_sum;

    logic             cmd_take;
    logic             issue;
    logic             is_bias;
    logic             last_neuron;
    logic             issue_last;
    logic [W_AW-1:0]  w_raddr;
    logic [VAL_W-1:0] w_rdata;
    logic [VAL_W-1:0] v_rdata;
    logic signed [VAL_W-1:0] x_op;

    t_out_word        r_oq [OQ_DEPTH];
    logic [OQ_AW-1:0] r_owp;
    logic [OQ_AW-1:0] r_orp;
    logic [OQ_CW-1:0] r_ocnt;
    logic             oq_push;
    logic             oq_pop;
    t_out_word        res;

    dlm_ram #(.WIDTH(VAL_W), .DEPTH(W_DEPTH)) u_wram (
        .i_clk   (i_clk),
        .i_we    (cmd_take && !i_cmd.is_elem),
        .i_waddr (i_cmd.addr),
        .i_wdata (i_cmd.value),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    dlm_ram #(.WIDTH(VAL_W), .DEPTH(MAX_INPUTS)) u_vram (
        .i_clk   (i_clk),
        .i_we    (cmd_take && i_cmd.is_elem),
        .i_waddr (i_cmd.addr[V_AW-1:0]),
        .i_wdata (i_cmd.value),
        .i_raddr (r_i[V_AW-1:0]),
        .o_rdata (v_rdata)
    );

    always_comb begin
        cmd_take    = (r_state == ST_IDLE) && i_cmd_valid;
        o_cmd_pop   = cmd_take;
        issue       = (r_state == ST_RUN)
                      && !((r_i == '0) && (r_pend >= OQ_CW'(OQ_DEPTH)));
        is_bias     = (r_i == i_cfg.n_in);
        last_neuron = ({1'b0, r_n} == (i_cfg.n_out - CNT_W'(1)));
        issue_last  = issue && is_bias;
        w_raddr     = r_base + W_AW'(r_i);

        s0.valid = issue;
        s0.first = (r_i == '0);
        s0.bias  = is_bias;
        s0.lastn = last_neuron;
        s0.n     = r_n;

        n_state = r_state;
        n_i     = r_i;
        n_n     = r_n;
        n_base  = r_base;
        case (r_state)
            ST_IDLE: begin
                if (cmd_take && i_cmd.run) begin
                    n_state = ST_RUN;
                    n_i     = '0;
                    n_n     = '0;
                    n_base  = '0;
                end
            end
            ST_RUN: begin
                if (issue) begin
                    if (is_bias) begin
                        n_i = '0;
                        if (last_neuron) begin
                            n_state = ST_IDLE;
                        end else begin
                            n_n    = r_n + ROW_W'(1);
                            n_base = r_base + W_AW'(ROW_LEN);
                        end
                    end else begin
                        n_i = r_i + CNT_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        x_op    = r_s1.bias ? BIAS_SCALE : $signed(v_rdata);
        acc_sum = (r_s2.first ? '0 : r_acc) + SUM_W'(r_prod);

        res.neuron_index   = r_s2.n;
        res.sum_out        = acc_sum;
        res.last_of_vector = r_s2.lastn;

        oq_push = r_s2.valid && r_s2.bias;
        o_empty = (r_ocnt == '0);
        oq_pop  = i_pop && !o_empty;
        o_word  = r_oq[r_orp];
    end

    always_ff @(posedge i_clk) begin
        r_prod <= $signed(w_rdata) * x_op;
        if (r_s2.valid) begin
            r_acc <= acc_sum;
        end
        if (oq_push) begin
            r_oq[r_owp] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_i     <= '0;
            r_n     <= '0;
            r_base  <= '0;
            r_s1    <= '0;
            r_s2    <= '0;
            r_pend  <= '0;
            r_owp   <= '0;
            r_orp   <= '0;
            r_ocnt  <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_n     <= n_n;
            r_base  <= n_base;
            r_s1    <= s0;
            r_s2    <= r_s1;
            r_pend  <= r_pend + OQ_CW'(issue_last) - OQ_CW'(oq_pop);
            if (oq_push) begin
                r_owp <= r_owp + OQ_AW'(1);
            end
            if (oq_pop) begin
                r_orp <= r_orp + OQ_AW'(1);
            end
            r_ocnt  <= r_ocnt + OQ_CW'(oq_push) - OQ_CW'(oq_pop);
        end
    end

endmodule
`default_nettype wire

### hdl/dense_layer_mac.sv
// Channel   Direction  Handshake               Word
// input     in         push / full             t_in_word  (weight write or vector element)
// result    out        pop / empty             t_out_word (one neuron sum)
// config    in         APB psel/penable/pready input_count @0x0, neuron_count @0x4
//
// Weight and element words: one per cycle while full is low, into a 2-deep command
// queue. A completing element issues neuron_count*(input_count+1) reads on the
// single multiply-accumulate pipe (one read per cycle from each RAM while not stalled);
// new input words queue meanwhile. Results sit in a 4-deep output queue;
// a full output queue stalls the pipe at neuron boundaries. Reset is synchronous and
// clears control state only; RAM contents stay undefined until written.
`default_nettype none
module dense_layer_mac import dlm_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire t_in_word    i_word,
    output logic             empty,
    input  wire logic        pop,
    output t_out_word        o_word,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    logic [CNT_W-1:0] r_input_count;
    logic [CNT_W-1:0] r_neuron_count;
    logic             cfg_we;
    t_cfg             cfg;
    logic             q_full;
    logic             q_push;
    t_cmd             q_in;
    logic             q_valid;
    logic             q_pop;
    t_cmd             q_out;

    always_comb begin
        pready    = 1'b1;
        cfg_we    = psel && penable && pwrite && pready;
        cfg.n_in  = eff_count(r_input_count, CNT_W'(MAX_INPUTS));
        cfg.n_out = eff_count(r_neuron_count, CNT_W'(MAX_NEURONS));
        case (paddr[2])
            REG_INPUT_COUNT:  prdata = 32'(r_input_count);
            REG_NEURON_COUNT: prdata = 32'(r_neuron_count);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_input_count  <= CNT_W'(64);
            r_neuron_count <= CNT_W'(64);
        end else if (cfg_we) begin
            case (paddr[2])
                REG_INPUT_COUNT:  r_input_count  <= pwdata[CNT_W-1:0];
                REG_NEURON_COUNT: r_neuron_count <= pwdata[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    dlm_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_push   (push),
        .i_word   (i_word),
        .o_full   (full),
        .i_q_full (q_full),
        .o_q_push (q_push),
        .o_q_cmd  (q_in)
    );

    dlm_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (q_out)
    );

    dlm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_out),
        .o_cmd_pop   (q_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_word      (o_word)
    );

endmodule
`default_nettype wire

### hdl/dlm_checker.sv
`default_nettype none
`include "assert_macros.svh"
module dlm_checker import dlm_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      empty,
    input wire logic      pop,
    input wire t_out_word o_word
);

    `ASSERT_NEXT_RAW(a_rst_empty, !i_rst_n, empty, "result queue not empty after reset")

    `ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(o_word), "stalled result word changed")

    `ASSERT_NEXT(a_next_neuron, pop && !empty && !o_word.last_of_vector, empty || (o_word.neuron_index == ROW_W'($past(o_word.neuron_index) + 1'b1)), "neuron order broken")

    `ASSERT_NEXT(a_wrap, pop && !empty && o_word.last_of_vector, empty || (o_word.neuron_index == '0), "new vector not starting at neuron zero")

endmodule

bind dense_layer_mac dlm_checker u_dlm_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .empty   (empty),
    .pop     (pop),
    .o_word  (o_word)
);
`default_nettype wire

### sim/dense_layer_mac_checker.sv
module dense_layer_mac_checker import dlm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  t_in_word    i_in_word,
    input  logic        i_empty,
    input  logic        i_pop,
    input  t_out_word   i_out_word,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_fail_count,
    output int          o_pending
);

    logic signed [VAL_W-1:0] weights [MAX_NEURONS][ROW_LEN];
    logic signed [VAL_W-1:0] elems [MAX_INPUTS];
    logic [CNT_W-1:0]        input_count_reg  = CNT_W'(MAX_INPUTS);
    logic [CNT_W-1:0]        neuron_count_reg = CNT_W'(MAX_NEURONS);
    int                      next_elem = 0;
    int                      fail_count = 0;
    t_out_word               sums_due [$];

    assign o_fail_count = fail_count;
    assign o_pending    = sums_due.size();

    function automatic int clamp_count(logic [CNT_W-1:0] v, int max_v);
        if (v == '0) begin
            return 1;
        end
        if (int'(v) > max_v) begin
            return max_v;
        end
        return int'(v);
    endfunction

    function automatic void take_word(t_in_word w);
        int        n_in;
        int        n_out;
        int        slot;
        longint    acc;
        t_out_word r;
        n_in  = clamp_count(input_count_reg, MAX_INPUTS);
        n_out = clamp_count(neuron_count_reg, MAX_NEURONS);
        if (w.action == ACT_WEIGHT) begin
            // columns past the bias slot are dropped
            if (w.weight_column <= MAX_INPUTS) begin
                weights[w.neuron_row][w.weight_column] = w.value;
            end
            return;
        end
        // counter past a shortened vector lands in the last slot
        slot = (next_elem >= n_in) ? n_in - 1 : next_elem;
        elems[slot] = w.value;
        if (slot + 1 < n_in) begin
            next_elem = slot + 1;
            return;
        end
        next_elem = 0;
        for (int n = 0; n < n_out; n++) begin
            acc = longint'(weights[n][n_in]) * longint'(BIAS_SCALE);
            for (int i = 0; i < n_in; i++) begin
                acc += longint'(weights[n][i]) * longint'(elems[i]);
            end
            r.neuron_index   = ROW_W'(n);
            r.sum_out        = acc[SUM_W-1:0];
            r.last_of_vector = (n == n_out - 1);
            sums_due.push_back(r);
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_out_word due;
        if (!i_rst_n) begin
            next_elem        = 0;
            input_count_reg  = CNT_W'(MAX_INPUTS);
            neuron_count_reg = CNT_W'(MAX_NEURONS);
            sums_due.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (sums_due.size() == 0) begin
                    $error("unexpected result word: neuron_index %0d sum_out %0d",
                           i_out_word.neuron_index, i_out_word.sum_out);
                    fail_count++;
                end else begin
                    due = sums_due.pop_front();
                    if (i_out_word.neuron_index !== due.neuron_index) begin
                        $error("neuron_index mismatch: expected %0d, actual %0d",
                               due.neuron_index, i_out_word.neuron_index);
                        fail_count++;
                    end
                    if (i_out_word.sum_out !== due.sum_out) begin
                        $error("sum_out mismatch: expected %0d, actual %0d",
                               due.sum_out, i_out_word.sum_out);
                        fail_count++;
                    end
                    if (i_out_word.last_of_vector !== due.last_of_vector) begin
                        $error("last_of_vector mismatch: expected %0d, actual %0d",
                               due.last_of_vector, i_out_word.last_of_vector);
                        fail_count++;
                    end
                end
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_INPUT_COUNT) begin
                    input_count_reg = i_pwdata[CNT_W-1:0];
                end else begin
                    neuron_count_reg = i_pwdata[CNT_W-1:0];
                end
            end
            if (i_push && !i_full) begin
                take_word(i_in_word);
            end
        end
    end

endmodule

### sim/dense_layer_mac_tb.sv
module dense_layer_mac_tb;
    import dlm_pkg::*;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 16;
    localparam int DRAIN_CYCLES   = 200;
    localparam int N_TABLE        = 8;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 16'sh8000;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 16'sh7fff;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push    = 1'b0;
    logic        full;
    t_in_word    in_word = '0;
    logic        empty;
    logic        pop     = 1'b0;
    t_out_word   out_word;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    idle_mode_e idle_mode = IDLE_NONE;
    bit         wt_written [MAX_NEURONS][ROW_LEN];
    int         n_in_eff  = MAX_INPUTS;
    int         n_out_eff = MAX_NEURONS;
    int         elem_pos  = 0;
    int         fail_count;
    int         pending;
    int         quiet_cycles = 0;

    int phase_in   [N_TABLE] = '{3, 1, 5, 0, 2, 4, 1, 3};
    int phase_out  [N_TABLE] = '{3, 4, 2, 5, 1, 6, 8, 0};
    int phase_vecs [N_TABLE] = '{4, 6, 3, 5, 4, 3, 4, 4};

    dense_layer_mac dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_word  (in_word),
        .empty   (empty),
        .pop     (pop),
        .o_word  (out_word),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    dense_layer_mac_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_full       (full),
        .i_in_word    (in_word),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_out_word   (out_word),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        int stall_pct;
        stall_pct = (idle_mode == IDLE_RECV) ? 59 : (idle_mode == IDLE_BOTH) ? 30 : 0;
        pop <= i_rst_n && ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) ||
            (psel && penable && pwrite && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic signed [VAL_W-1:0] rand_value();
        case ($urandom_range(7))
            0: begin
                return VAL_MIN;
            end
            1: begin
                return VAL_MAX;
            end
            2: begin
                return '0;
            end
            default: begin
                return VAL_W'($urandom);
            end
        endcase
    endfunction

    task automatic put_word(input t_in_word w);
        int gap_pct;
        gap_pct = (idle_mode == IDLE_SEND) ? 59 : (idle_mode == IDLE_BOTH) ? 30 : 0;
        @(negedge i_clk);
        while ($urandom_range(99) < gap_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push    <= 1'b1;
        in_word <= w;
        do @(posedge i_clk); while (full);
    endtask

    task automatic end_push();
        @(negedge i_clk);
        push <= 1'b0;
    endtask

    task automatic write_weight(input int row, input int col,
                                input logic signed [VAL_W-1:0] val);
        t_in_word w;
        w.action        = ACT_WEIGHT;
        w.neuron_row    = ROW_W'(row);
        w.weight_column = CNT_W'(col);
        w.value         = val;
        if (col <= MAX_INPUTS) begin
            wt_written[row][col] = 1'b1;
        end
        put_word(w);
    endtask

    task automatic put_element(input logic signed [VAL_W-1:0] val);
        t_in_word w;
        int       slot;
        w.action        = ACT_DATA;
        w.neuron_row    = ROW_W'($urandom_range(MAX_NEURONS - 1));
        w.weight_column = CNT_W'($urandom_range(127));
        w.value         = val;
        put_word(w);
        slot     = (elem_pos >= n_in_eff) ? n_in_eff - 1 : elem_pos;
        elem_pos = (slot + 1 < n_in_eff) ? slot + 1 : 0;
    endtask

    task automatic write_reg(input logic idx, input logic [CNT_W-1:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(val);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    task automatic set_config(input logic [CNT_W-1:0] n_in_raw,
                              input logic [CNT_W-1:0] n_out_raw);
        end_push();
        while (pending != 0) begin
            @(negedge i_clk);
        end
        // queued words that make no result may still be in flight
        repeat (HOLD_CYCLES) @(negedge i_clk);
        write_reg(REG_INPUT_COUNT, n_in_raw);
        write_reg(REG_NEURON_COUNT, n_out_raw);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        n_in_eff  = (n_in_raw == 0) ? 1 :
                    (n_in_raw > MAX_INPUTS) ? MAX_INPUTS : int'(n_in_raw);
        n_out_eff = (n_out_raw == 0) ? 1 :
                    (n_out_raw > MAX_NEURONS) ? MAX_NEURONS : int'(n_out_raw);
    endtask

    // every weight a completing vector reads must exist first
    task automatic fill_weights();
        for (int r = 0; r < n_out_eff; r++) begin
            for (int c = 0; c <= n_in_eff; c++) begin
                if (!wt_written[r][c]) begin
                    write_weight(r, c, rand_value());
                end
            end
        end
    endtask

    task automatic run_vector();
        int limit;
        repeat ($urandom_range(3)) begin
            write_weight($urandom_range(MAX_NEURONS - 1), $urandom_range(127), rand_value());
        end
        fill_weights();
        // now and then a vector is cut short and resumed later
        limit = ($urandom_range(5) == 0) ? $urandom_range(n_in_eff, 1) : ROW_LEN;
        do begin
            put_element(rand_value());
            limit--;
        end while (elem_pos != 0 && limit > 0);
    endtask

    initial begin
        int n_in_raw;
        int n_out_raw;
        int vecs;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        set_config(CNT_W'(2), CNT_W'(2));
        write_weight(0, 0, VAL_MIN);
        write_weight(0, 1, VAL_MIN);
        write_weight(0, 2, VAL_MIN);
        write_weight(1, 0, VAL_MAX);
        write_weight(1, 1, VAL_MAX);
        write_weight(1, 2, VAL_MAX);
        write_weight(63, 65, rand_value());
        write_weight(63, 127, rand_value());
        put_element(VAL_MIN);
        put_element(VAL_MIN);
        put_element(VAL_MAX);
        put_element(VAL_MAX);
        put_element('0);
        // length drops under the element counter, next element completes
        set_config(CNT_W'(0), CNT_W'(2));
        put_element(VAL_MAX);
        set_config(CNT_W'(0), CNT_W'(0));
        put_element(VAL_MIN);

        for (int p = 0; p < N_TABLE; p++) begin
            n_in_raw  = phase_in[p];
            n_out_raw = phase_out[p];
            vecs      = phase_vecs[p];
            set_config(CNT_W'(n_in_raw), CNT_W'(n_out_raw));
            idle_mode = idle_mode_e'(p % 4);
            repeat (vecs) run_vector();
        end

        end_push();
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
